// ===== rtl/core/gated_channel_charge_histogram_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the charge histogram block
// Shorthand for clocked implication checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef GATED_CHANNEL_CHARGE_HISTOGRAM_MACROS_SVH
`define GATED_CHANNEL_CHARGE_HISTOGRAM_MACROS_SVH

// same-cycle implication
`define GCCH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gcch_pkg.sv =====
// ----------------------------------------------------------------------------
// gcch_pkg
// Types and constants shared by the charge histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcch_pkg;

  // default geometry
  localparam int NUM_CHANNELS_DEF = 60;
  localparam int NUM_BINS_DEF     = 250;

  // field widths
  localparam int CMD_W       = 2;
  localparam int SEC_W       = 32;
  localparam int NSEC_W      = 30;
  localparam int LOC_W       = 16;
  localparam int AMP_W       = 16;
  localparam int CH_W        = 6;
  localparam int CHARGE_W    = 28;
  localparam int READ_BIN_W  = 8;
  localparam int COUNT_W     = 32;
  localparam int TIME_W      = 64;
  localparam int GAP_W       = 30;
  localparam int BIN_WIDTH_W = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 30;

  // timestamp multiply: seconds times one billion, one constant bit a step
  localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;
  localparam int MUL_STEPS = NSEC_W;

  // magnitude bits of a non-negative charge, one quotient bit a step
  localparam int DIV_STEPS = CHARGE_W - 1;

  localparam int STEP_CNT_W = 5;

  // register reset values
  localparam logic [GAP_W-1:0]       MIN_GAP_RST   = 30'd20000;
  localparam logic [LOC_W-1:0]       EARLY_RST     = 16'd10;
  localparam logic [LOC_W-1:0]       LATE_RST      = 16'd150;
  localparam logic [AMP_W-1:0]       AMP_LIMIT_RST = 16'd110;
  localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RST = 20'd640;

  typedef enum logic [CMD_W-1:0] {
    CMD_HEADER = 2'd0,
    CMD_PEAK   = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GAP   = 3'd0,
    CFG_EARLY     = 3'd1,
    CFG_LATE      = 3'd2,
    CFG_AMP_LIMIT = 3'd3,
    CFG_BIN_WIDTH = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_GAP,
    ST_VETO,
    ST_DIV,
    ST_BIN,
    ST_ADDR,
    ST_RD,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/gcch_ram.sv =====
// ----------------------------------------------------------------------------
// gcch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gcch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gated_channel_charge_histogram.sv =====
// ----------------------------------------------------------------------------
// gated_channel_charge_histogram
// Per-channel charge histogram with event time veto and peak based rejection.
// ----------------------------------------------------------------------------
// One item is taken at a time; item_ready is low while it is worked on. A
// peak beat or a gated-off channel close is handled on acceptance. An event
// header runs 30 shift-add steps to form seconds times one billion plus
// nanoseconds, then two subtracts check the gap to the previous event. A
// negative charge goes straight to address, count read and count write-back;
// any other charge first runs 27 restoring divide steps by bin_width and a
// bin select. A read bin beat runs address and count read before the result
// register (neither when the channel is out of range), and waits in the
// response step if the previous result has not been taken. The multiply,
// gap and divide steps use one shared 64-bit add/subtract unit. After reset
// a clearing pass zeroes the NUM_CHANNELS*(NUM_BINS+2) count entries (15120
// at the defaults), one entry a cycle, and no item is taken until it ends;
// config writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gated_channel_charge_histogram_macros.svh"

module gated_channel_charge_histogram
  import gcch_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_BINS     = NUM_BINS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // config write channel
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  // item channel
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire logic [CMD_W-1:0]           command,
  input  wire logic [SEC_W-1:0]           seconds,
  input  wire logic [NSEC_W-1:0]          nanoseconds,
  input  wire logic [LOC_W-1:0]           peak_location,
  input  wire logic [AMP_W-1:0]           peak_amplitude,
  input  wire logic [CH_W-1:0]            channel,
  input  wire logic signed [CHARGE_W-1:0] charge_value,
  input  wire logic [READ_BIN_W-1:0]      read_bin,
  // result channel
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output logic [COUNT_W-1:0]              bin_count,
  output logic                            read_status
);

  localparam int BINS_PER_CH = NUM_BINS + 2;
  localparam int DEPTH       = NUM_CHANNELS * BINS_PER_CH;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int BIN_W       = $clog2(BINS_PER_CH);

  // config registers
  logic [GAP_W-1:0]       min_gap_ns;
  logic [LOC_W-1:0]       early_location;
  logic [LOC_W-1:0]       late_location;
  logic [AMP_W-1:0]       amplitude_limit;
  logic [BIN_WIDTH_W-1:0] bin_width;

  // event state
  logic [TIME_W-1:0] last_time_ns;
  logic              event_vetoed;
  logic              channel_rejected;

  // sequencer and datapath
  state_t                 state, state_next;
  logic [STEP_CNT_W-1:0]  cnt;
  logic [TIME_W-1:0]      acc;
  logic [TIME_W-1:0]      msh;
  logic [TIME_W-1:0]      diff;
  logic                   time_back;
  logic [BIN_WIDTH_W-1:0] rem;
  logic [DIV_STEPS-1:0]   dvd;
  logic [DIV_STEPS-1:0]   quo;
  logic [BIN_W-1:0]       bin;
  logic [CH_W-1:0]        ch_r;
  logic                   is_read;
  logic                   ch_oor;
  logic [ADDR_W-1:0]      addr;
  logic [ADDR_W-1:0]      clr_addr;

  // shared add/subtract unit
  logic [TIME_W-1:0] alu_a, alu_b;
  logic              alu_sub;
  logic [TIME_W:0]   alu_sum;
  logic              alu_carry;

  // memory port
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  logic item_acc;
  logic ch_in_oor;
  logic close_gated;
  logic res_free;
  logic clr_last;

  assign cfg_ready   = 1'b1;
  assign item_ready  = (state == ST_IDLE);
  assign item_acc    = item_valid && item_ready;
  assign ch_in_oor   = {1'b0, channel} >= (CH_W+1)'(NUM_CHANNELS);
  assign close_gated = event_vetoed || channel_rejected || ch_in_oor;
  assign res_free    = !result_valid || result_ready;
  assign clr_last    = (clr_addr == ADDR_W'(DEPTH - 1));

  // config writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_ns      <= MIN_GAP_RST;
      early_location  <= EARLY_RST;
      late_location   <= LATE_RST;
      amplitude_limit <= AMP_LIMIT_RST;
      bin_width       <= BIN_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_GAP:   min_gap_ns      <= cfg_data[GAP_W-1:0];
        CFG_EARLY:     early_location  <= cfg_data[LOC_W-1:0];
        CFG_LATE:      late_location   <= cfg_data[LOC_W-1:0];
        CFG_AMP_LIMIT: amplitude_limit <= cfg_data[AMP_W-1:0];
        CFG_BIN_WIDTH: bin_width       <= cfg_data[BIN_WIDTH_W-1:0];
        default:       ;
      endcase
    end
  end

  // shared unit: a + b or a - b, carry out high means no borrow
  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (TIME_W+1)'(alu_sub);
  assign alu_carry = alu_sum[TIME_W];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, unit operands and memory controls
  always_comb begin
    state_next = state;
    alu_a      = acc;
    alu_b      = msh;
    alu_sub    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = addr;
    ram_wdata  = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_W'(1);
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_acc) begin
          unique case (cmd_t'(command))
            CMD_HEADER: state_next = ST_MUL;
            CMD_PEAK:   state_next = ST_IDLE;
            CMD_CLOSE: begin
              if (close_gated) begin
                state_next = ST_IDLE;
              end else if (charge_value < 0) begin
                state_next = ST_ADDR;
              end else begin
                state_next = ST_DIV;
              end
            end
            CMD_READ:   state_next = ch_in_oor ? ST_RESP : ST_ADDR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        if (cnt == STEP_CNT_W'(MUL_STEPS - 1)) begin
          state_next = ST_GAP;
        end
      end
      ST_GAP: begin
        alu_b   = last_time_ns;
        alu_sub = 1'b1;
        state_next = ST_VETO;
      end
      ST_VETO: begin
        alu_a   = diff;
        alu_b   = TIME_W'(min_gap_ns);
        alu_sub = 1'b1;
        state_next = ST_IDLE;
      end
      ST_DIV: begin
        alu_a   = TIME_W'({rem, dvd[DIV_STEPS-1]});
        alu_b   = TIME_W'(bin_width);
        alu_sub = 1'b1;
        if (cnt == '0) begin
          state_next = ST_BIN;
        end
      end
      ST_BIN:  state_next = ST_ADDR;
      ST_ADDR: state_next = ST_RD;
      ST_RD: begin
        ram_re     = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (is_read) begin
          if (res_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and event flags
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time_ns     <= '0;
      event_vetoed     <= 1'b0;
      channel_rejected <= 1'b0;
      clr_addr         <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (item_acc) begin
            ch_r    <= channel;
            is_read <= (cmd_t'(command) == CMD_READ);
            ch_oor  <= ch_in_oor;
            unique case (cmd_t'(command))
              CMD_HEADER: begin
                acc              <= TIME_W'(nanoseconds);
                msh              <= TIME_W'(seconds);
                cnt              <= '0;
                channel_rejected <= 1'b0;
              end
              CMD_PEAK: begin
                if ((peak_location < early_location) ||
                    ((peak_location < late_location) &&
                     (peak_amplitude > amplitude_limit))) begin
                  channel_rejected <= 1'b1;
                end
              end
              CMD_CLOSE: begin
                channel_rejected <= 1'b0;
                bin <= '0;
                rem <= '0;
                dvd <= charge_value[DIV_STEPS-1:0];
                cnt <= STEP_CNT_W'(DIV_STEPS - 1);
              end
              CMD_READ: begin
                if (32'(read_bin) > 32'(NUM_BINS + 1)) begin
                  bin <= BIN_W'(NUM_BINS + 1);
                end else begin
                  bin <= BIN_W'(read_bin);
                end
              end
              default: ;
            endcase
          end
        end
        // accumulate seconds shifted by each set bit of one billion
        ST_MUL: begin
          if (NS_PER_SEC[cnt]) begin
            acc <= alu_sum[TIME_W-1:0];
          end
          msh <= {msh[TIME_W-2:0], 1'b0};
          cnt <= cnt + STEP_CNT_W'(1);
        end
        ST_GAP: begin
          diff      <= alu_sum[TIME_W-1:0];
          time_back <= !alu_carry;
        end
        ST_VETO: begin
          event_vetoed <= time_back || !alu_carry;
          last_time_ns <= acc;
        end
        // restoring divide, one quotient bit a step
        ST_DIV: begin
          if (alu_carry) begin
            rem <= alu_sum[BIN_WIDTH_W-1:0];
          end else begin
            rem <= {rem[BIN_WIDTH_W-2:0], dvd[DIV_STEPS-1]};
          end
          quo <= {quo[DIV_STEPS-2:0], alu_carry};
          dvd <= {dvd[DIV_STEPS-2:0], 1'b0};
          cnt <= cnt - STEP_CNT_W'(1);
        end
        ST_BIN: begin
          if (quo >= DIV_STEPS'(NUM_BINS)) begin
            bin <= BIN_W'(NUM_BINS + 1);
          end else begin
            bin <= BIN_W'(quo) + BIN_W'(1);
          end
        end
        ST_ADDR: begin
          addr <= ADDR_W'(ADDR_W'(ch_r) * ADDR_W'(BINS_PER_CH)) + ADDR_W'(bin);
        end
        default: ;
      endcase
    end
  end

  // count store
  gcch_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_RESP) && is_read && res_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESP) && is_read && res_free) begin
      bin_count   <= ch_oor ? '0 : ram_rdata;
      read_status <= ch_oor;
    end
  end

  // checks
  `GCCH_ASSERT_IMPL(a_bin_range, state == ST_ADDR, bin <= BIN_W'(NUM_BINS + 1),
    "bin index beyond overflow bin")
  `GCCH_ASSERT_IMPL(a_addr_range, state == ST_RD, addr <= ADDR_W'(DEPTH - 1),
    "count address beyond store")
  `GCCH_ASSERT_IMPL(a_write_src, ram_we && (state != ST_CLEAR),
    (state == ST_RESP) && !is_read, "count write outside a fill")
  `GCCH_ASSERT_IMPL(a_result_src, $rose(result_valid), $past(state) == ST_RESP,
    "result loaded outside response step")
  `GCCH_ASSERT_NEXT(a_time_update, state == ST_VETO,
    (state == ST_IDLE) && (last_time_ns == $past(acc)), "event time not stored")

endmodule

`default_nettype wire

// ===== tb/sv/tb_gated_channel_charge_histogram.sv =====
// ----------------------------------------------------------------------------
// tb_gated_channel_charge_histogram
// Drives header, peak, close and read beats into the charge histogram and
// checks every read result against a cycle-free model of the veto, reject
// and binning rules kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gated_channel_charge_histogram;
  import gcch_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int NB  = NUM_BINS_DEF;
  localparam int OVF_BIN = NB + 1;
  localparam logic [TIME_W-1:0] SEC_NS = 64'd1000000000;
  localparam logic [63:0] CHARGE_MAX = 64'd134217727;
  // idle time after the last result before a register write or the verdict
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    cmd_t                        cmd;
    logic [SEC_W-1:0]            sec;
    logic [NSEC_W-1:0]           nsec;
    logic [LOC_W-1:0]            loc;
    logic [AMP_W-1:0]            amp;
    logic [CH_W-1:0]             ch;
    logic signed [CHARGE_W-1:0]  charge;
    logic [READ_BIN_W-1:0]       rbin;
  } hist_item_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               status;
  } read_result_t;

  // DUT ports
  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        item_valid = 1'b0;
  logic                        item_ready;
  logic [CMD_W-1:0]            command = '0;
  logic [SEC_W-1:0]            seconds = '0;
  logic [NSEC_W-1:0]           nanoseconds = '0;
  logic [LOC_W-1:0]            peak_location = '0;
  logic [AMP_W-1:0]            peak_amplitude = '0;
  logic [CH_W-1:0]             channel = '0;
  logic signed [CHARGE_W-1:0]  charge_value = '0;
  logic [READ_BIN_W-1:0]       read_bin = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  logic [COUNT_W-1:0]          bin_count;
  logic                        read_status;

  // model of the histogram state and registers
  logic [GAP_W-1:0]       reg_min_gap   = MIN_GAP_RST;
  logic [LOC_W-1:0]       reg_early     = EARLY_RST;
  logic [LOC_W-1:0]       reg_late      = LATE_RST;
  logic [AMP_W-1:0]       reg_amp_limit = AMP_LIMIT_RST;
  logic [BIN_WIDTH_W-1:0] reg_bin_width = BIN_WIDTH_RST;
  logic [TIME_W-1:0]      prev_event_ns = '0;
  bit                     event_veto = 1'b0;
  bit                     chan_reject = 1'b0;
  logic [COUNT_W-1:0]     counts [NCH][NB+2];

  read_result_t           pending_reads [$];
  read_result_t           head_read;
  int                     mismatch_count = 0;

  // stimulus bookkeeping
  int unsigned            burst_left = 0;
  bit                     sender_gaps = 1'b1;
  int unsigned            items_sent = 0;
  logic [TIME_W-1:0]      event_clock = '0;
  logic [CH_W-1:0]        last_fill_ch = '0;
  int unsigned            last_fill_bin = 1;

  gated_channel_charge_histogram dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .command        (command),
    .seconds        (seconds),
    .nanoseconds    (nanoseconds),
    .peak_location  (peak_location),
    .peak_amplitude (peak_amplitude),
    .channel        (channel),
    .charge_value   (charge_value),
    .read_bin       (read_bin),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .bin_count      (bin_count),
    .read_status    (read_status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Model
  // ------------------------------------------------------------------------

  // histogram bin of a charge: underflow for negative, overflow past NB
  function automatic int unsigned charge_to_bin(logic signed [CHARGE_W-1:0] q);
    logic [31:0] quot;
    if (q[CHARGE_W-1])
      return 0;
    if (reg_bin_width == '0)
      return OVF_BIN;
    quot = 32'(unsigned'(q)) / 32'(reg_bin_width);
    if (quot >= NB)
      return OVF_BIN;
    return quot + 1;
  endfunction

  // apply one accepted beat to the histogram model; queue a read result
  function automatic void update_histogram_model(hist_item_t it);
    logic [TIME_W-1:0] t;
    int unsigned       b;
    read_result_t      r;
    case (it.cmd)
      CMD_HEADER: begin
        t = TIME_W'(it.sec) * SEC_NS + TIME_W'(it.nsec);
        event_veto = (t < prev_event_ns) || ((t - prev_event_ns) < TIME_W'(reg_min_gap));
        prev_event_ns = t;
        chan_reject = 1'b0;
      end
      CMD_PEAK: begin
        if (it.loc < reg_early || (it.loc < reg_late && it.amp > reg_amp_limit))
          chan_reject = 1'b1;
      end
      CMD_CLOSE: begin
        if (!event_veto && !chan_reject && it.ch < NCH) begin
          b = charge_to_bin(it.charge);
          if (counts[it.ch][b] != '1)
            counts[it.ch][b] = counts[it.ch][b] + 1'b1;
          last_fill_ch = it.ch;
          last_fill_bin = b;
        end
        chan_reject = 1'b0;
      end
      default: begin
        b = (it.rbin > OVF_BIN) ? OVF_BIN : it.rbin;
        if (it.ch >= NCH) begin
          r.count = '0;
          r.status = 1'b1;
        end else begin
          r.count = counts[it.ch][b];
          r.status = 1'b0;
        end
        pending_reads.push_back(r);
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result beat: bin_count %0d read_status %0d",
               bin_count, read_status);
        mismatch_count++;
      end else begin
        head_read = pending_reads.pop_front();
        if (bin_count !== head_read.count) begin
          $error("bin_count mismatch: expected %0d, actual %0d",
                 head_read.count, bin_count);
          mismatch_count++;
        end
        if (read_status !== head_read.status) begin
          $error("read_status mismatch: expected %0d, actual %0d",
                 head_read.status, read_status);
          mismatch_count++;
        end
      end
    end
  end

  // result side back-pressure: open stretches, long stalls, choppy runs
  initial begin
    bit          level;
    int unsigned run;
    forever begin
      case ($urandom_range(0, 3))
        0: begin
          level = 1'b1;
          run = $urandom_range(20, 120);
        end
        1: begin
          level = 1'b0;
          run = $urandom_range(1, 20);
        end
        default: begin
          level = 1'($urandom_range(0, 1));
          run = $urandom_range(1, 4);
        end
      endcase
      @(negedge clk);
      result_ready <= level;
      repeat (run - 1) @(negedge clk);
    end
  end

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------

  // one item beat; entered right after the previous accept edge
  task automatic send_item(input hist_item_t it);
    int unsigned gap;
    @(negedge clk);
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps)
        gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command        <= it.cmd;
    seconds        <= it.sec;
    nanoseconds    <= it.nsec;
    peak_location  <= it.loc;
    peak_amplitude <= it.amp;
    channel        <= it.ch;
    charge_value   <= it.charge;
    read_bin       <= it.rbin;
    item_valid     <= 1'b1;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    update_histogram_model(it);
  endtask

  // drop valid, drain all reads, then let a slow header or close finish
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_GAP:   reg_min_gap   = data[GAP_W-1:0];
      CFG_EARLY:     reg_early     = data[LOC_W-1:0];
      CFG_LATE:      reg_late      = data[LOC_W-1:0];
      CFG_AMP_LIMIT: reg_amp_limit = data[AMP_W-1:0];
      CFG_BIN_WIDTH: reg_bin_width = data[BIN_WIDTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] gap, input logic [CFG_DATA_W-1:0] early,
                           input logic [CFG_DATA_W-1:0] late, input logic [CFG_DATA_W-1:0] amp,
                           input logic [CFG_DATA_W-1:0] width);
    wait_idle();
    write_reg(CFG_MIN_GAP, gap);
    write_reg(CFG_EARLY, early);
    write_reg(CFG_LATE, late);
    write_reg(CFG_AMP_LIMIT, amp);
    write_reg(CFG_BIN_WIDTH, width);
  endtask

  // every field random; the command picks which ones matter
  function automatic hist_item_t rand_item(cmd_t c);
    hist_item_t it;
    it.cmd    = c;
    it.sec    = $urandom;
    it.nsec   = NSEC_W'($urandom);
    it.loc    = LOC_W'($urandom);
    it.amp    = AMP_W'($urandom);
    it.ch     = CH_W'($urandom);
    it.charge = CHARGE_W'($urandom);
    it.rbin   = READ_BIN_W'($urandom);
    return it;
  endfunction

  task automatic send_header(input logic [SEC_W-1:0] s, input logic [NSEC_W-1:0] ns);
    hist_item_t it;
    it = rand_item(CMD_HEADER);
    it.sec = s;
    it.nsec = ns;
    send_item(it);
  endtask

  task automatic send_peak(input logic [LOC_W-1:0] loc, input logic [AMP_W-1:0] amp);
    hist_item_t it;
    it = rand_item(CMD_PEAK);
    it.loc = loc;
    it.amp = amp;
    send_item(it);
  endtask

  task automatic send_close(input logic [CH_W-1:0] ch, input logic signed [CHARGE_W-1:0] q);
    hist_item_t it;
    it = rand_item(CMD_CLOSE);
    it.ch = ch;
    it.charge = q;
    send_item(it);
  endtask

  task automatic send_read(input logic [CH_W-1:0] ch, input logic [READ_BIN_W-1:0] b);
    hist_item_t it;
    it = rand_item(CMD_READ);
    it.ch = ch;
    it.rbin = b;
    send_item(it);
  endtask

  // one event: header, then a few channels of peaks and a close each,
  // with reads mostly aimed at bins that were just filled
  task automatic send_random_event();
    hist_item_t        it;
    logic [TIME_W-1:0] step;
    logic [63:0]       hi;
    int unsigned       n_ch;
    int unsigned       n_pk;
    it = rand_item(CMD_HEADER);
    case ($urandom_range(0, 9))
      0: begin
        // too close to the previous event
        step = (reg_min_gap == '0) ? '0 : TIME_W'($urandom_range(0, reg_min_gap - 1));
        event_clock += step;
      end
      1: begin
        // free-running timestamp, may jump back or carry a large nanosecond part
        event_clock = TIME_W'(it.sec) * SEC_NS + TIME_W'(it.nsec);
      end
      default: begin
        step = TIME_W'(reg_min_gap) + TIME_W'($urandom_range(0, 50000));
        event_clock += step;
      end
    endcase
    if (event_clock / SEC_NS > 64'hFFFF_FFFF)
      event_clock = TIME_W'($urandom_range(0, 1000000));
    if (it.sec != event_clock / SEC_NS || it.nsec >= SEC_NS) begin
      if (TIME_W'(it.sec) * SEC_NS + TIME_W'(it.nsec) != event_clock) begin
        it.sec = SEC_W'(event_clock / SEC_NS);
        it.nsec = NSEC_W'(event_clock % SEC_NS);
      end
    end
    send_item(it);

    n_ch = $urandom_range(1, 4);
    repeat (n_ch) begin
      n_pk = $urandom_range(0, 3);
      repeat (n_pk) begin
        it = rand_item(CMD_PEAK);
        case ($urandom_range(0, 3))
          0: it.loc = reg_early + LOC_W'($urandom_range(0, 6)) - LOC_W'(3);
          1: it.loc = reg_late + LOC_W'($urandom_range(0, 6)) - LOC_W'(3);
          2: it.loc = reg_late + LOC_W'($urandom_range(0, 200));
          default: ;
        endcase
        if ($urandom_range(0, 1) == 0)
          it.amp = reg_amp_limit + AMP_W'($urandom_range(0, 6)) - AMP_W'(3);
        send_item(it);
      end

      it = rand_item(CMD_CLOSE);
      if ($urandom_range(0, 15) == 0)
        it.ch = CH_W'($urandom_range(NCH, 63));
      else
        it.ch = CH_W'($urandom_range(0, NCH - 1));
      case ($urandom_range(0, 7))
        6: it.charge = CHARGE_W'($urandom) | {1'b1, {(CHARGE_W-1){1'b0}}};
        7: ;
        default: begin
          hi = (reg_bin_width == '0) ? 64'd1000 : 64'(reg_bin_width) * (NB + 2);
          if (hi > CHARGE_MAX)
            hi = CHARGE_MAX;
          it.charge = CHARGE_W'($urandom_range(0, 32'(hi)));
        end
      endcase
      send_item(it);

      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 2) != 0)
          send_read(last_fill_ch, READ_BIN_W'(last_fill_bin));
        else
          send_read(CH_W'($urandom), READ_BIN_W'($urandom));
      end
    end
  endtask

  task automatic run_events(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at)
      send_random_event();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // event gap veto at reset settings, backward time, oversize nanoseconds
  task automatic test_event_veto();
    send_header(32'd1, 30'd0);
    send_close(6'd0, 28'sd0);
    send_read(6'd0, 8'd1);
    send_header(32'd1, 30'd10000);
    send_close(6'd0, 28'sd0);
    send_read(6'd0, 8'd1);
    send_header(32'd0, 30'd5);
    send_header(32'd2, 30'h3FFF_FFFF);
  endtask

  // early peak, high amplitude before the late limit, and the limit edges
  task automatic test_peak_rejection();
    send_peak(16'd9, 16'd0);
    send_close(6'd1, 28'sd3200);
    send_peak(16'd149, 16'd111);
    send_close(6'd1, 28'sd3200);
    send_peak(16'd150, 16'hFFFF);
    send_peak(16'd10, 16'd110);
    send_close(6'd1, 28'sd3200);
    send_read(6'd1, 8'd6);
  endtask

  // underflow, overflow, top regular bin, channel and bin index limits
  task automatic test_charge_binning();
    send_close(6'd2, -28'sd134217728);
    send_close(6'd2, 28'sd134217727);
    send_close(6'd2, 28'sd159999);
    send_close(6'd63, 28'sd0);
    send_read(6'd63, 8'd0);
    send_read(6'd2, 8'd255);
    send_read(6'd2, 8'd0);
    send_read(6'd2, 8'd250);
  endtask

  task automatic test_config_low_extremes();
    configure(30'd0, 30'd0, 30'd0, 30'd0, 30'd1);
    run_events(80);
  endtask

  task automatic test_config_high_extremes();
    configure(30'd1000000000, 30'd65535, 30'd65535, 30'd65535, 30'd1048575);
    run_events(60);
  endtask

  // all non-negative charges land in overflow
  task automatic test_zero_bin_width();
    configure(30'd20000, 30'd10, 30'd150, 30'd110, 30'd0);
    run_events(60);
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] gap;
    logic [CFG_DATA_W-1:0] width;
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 3))
        0: gap = 30'd0;
        1: gap = CFG_DATA_W'($urandom_range(0, 1000));
        2: gap = CFG_DATA_W'($urandom_range(1000, 100000));
        default: gap = CFG_DATA_W'($urandom_range(0, 1000000000));
      endcase
      width = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(1, 1048575))
                                          : CFG_DATA_W'($urandom_range(1, 4000));
      configure(gap, CFG_DATA_W'($urandom_range(0, 40)), CFG_DATA_W'($urandom_range(0, 300)),
                ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom)
                                            : CFG_DATA_W'($urandom_range(0, 300)), width);
      sender_gaps = (ph % 2 == 0);
      run_events(140);
    end
    sender_gaps = 1'b1;
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    for (int c = 0; c < NCH; c++)
      for (int b = 0; b < NB + 2; b++)
        counts[c][b] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_event_veto();
    test_peak_rejection();
    test_charge_binning();
    test_config_low_extremes();
    test_config_high_extremes();
    test_zero_bin_width();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
